### hdl/ttrr_pkg.sv
// ----------------------------------------------------------------------------
// ttrr_pkg
// Shared types and constants of the round-robin task table: command codes,
// result codes, task states and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ttrr_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_ID_BITS       = 16;
    localparam int OP_BITS           = 4;
    localparam int STATUS_BITS       = 2;
    localparam int RUN_BITS          = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_CREATE   = 4'd0,
        OP_SCHEDULE = 4'd1,
        OP_BLOCK    = 4'd2,
        OP_UNBLOCK  = 4'd3,
        OP_SLEEP    = 4'd4,
        OP_STOP     = 4'd5,
        OP_CONTINUE = 4'd6,
        OP_EXIT     = 4'd7,
        OP_QUERY    = 4'd8
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOTHING   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        TS_READY    = 3'd0,
        TS_RUNNING  = 3'd1,
        TS_BLOCKED  = 3'd2,
        TS_SLEEPING = 3'd3,
        TS_STOPPED  = 3'd4,
        TS_ZOMBIE   = 3'd5
    } task_state_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_FIND,
        SCAN_CHILD,
        SCAN_PICK
    } scan_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_FIND,
        S_APPLY,
        S_CHILD,
        S_PICK,
        S_CUR_RD,
        S_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic  accept;
        logic  create;
        logic  apply;
        logic  load;
        scan_t scan;
        scan_t init_kind;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic hit;
        logic exhausted;
    } dp_stat_t;

endpackage

### hdl/ttrr_datapath.sv
// ----------------------------------------------------------------------------
// ttrr_datapath
// Task table memories, scan engine (one entry per cycle), current slot,
// id allocator and the result register.
// ----------------------------------------------------------------------------
module ttrr_datapath #(
    parameter int TABLE_ENTRIES = ttrr_pkg::DEF_TABLE_ENTRIES,
    parameter int ID_BITS       = ttrr_pkg::DEF_ID_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ttrr_pkg::OP_BITS-1:0]        operation,
    input  logic [ID_BITS-1:0]                  target_id,
    input  logic [ID_BITS-1:0]                  parent_id,
    input  ttrr_pkg::dp_cmd_t                   cmd,
    output ttrr_pkg::dp_stat_t                  stat,
    output logic [ttrr_pkg::STATUS_BITS-1:0]    status,
    output logic [ID_BITS-1:0]                  result_id,
    output logic [ID_BITS-1:0]                  current_id,
    output logic [ttrr_pkg::RUN_BITS-1:0]       current_run_count
);
    import ttrr_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [IW-1:0]      LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0]      ALL_SLOTS = CW'(TABLE_ENTRIES);
    localparam logic [ID_BITS-1:0] ROOT_ID = ID_BITS'(1);

    // table storage
    logic [ID_BITS-1:0]  id_mem     [TABLE_ENTRIES];
    logic [ID_BITS-1:0]  parent_mem [TABLE_ENTRIES];
    task_state_t         state_mem  [TABLE_ENTRIES];
    logic [RUN_BITS-1:0] count_mem  [TABLE_ENTRIES];

    // control registers
    op_t                 op_reg,      op_next;
    logic [CW-1:0]       fill_reg,    fill_next;
    logic [IW-1:0]       cur_reg,     cur_next;
    logic [ID_BITS-1:0]  next_id_reg, next_id_next;
    logic [IW-1:0]       idx_reg,     idx_next;
    logic [CW-1:0]       cnt_reg,     cnt_next;
    logic                eval_reg,    eval_next;

    // payload registers
    logic [ID_BITS-1:0]  tid_reg,       tid_next;
    logic [ID_BITS-1:0]  pid_reg,       pid_next;
    logic [IW-1:0]       hit_slot_reg,  hit_slot_next;
    task_state_t         hit_state_reg, hit_state_next;
    status_t             status_reg,    status_next;
    logic [ID_BITS-1:0]  result_reg,    result_next;
    logic [IW-1:0]       rd_addr_reg;
    logic [ID_BITS-1:0]  rd_id_reg;
    logic [ID_BITS-1:0]  rd_parent_reg;
    task_state_t         rd_state_reg;
    logic [RUN_BITS-1:0] rd_count_reg;
    status_t             out_status_reg,  out_status_next;
    logic [ID_BITS-1:0]  out_result_reg,  out_result_next;
    logic [ID_BITS-1:0]  out_cur_id_reg,  out_cur_id_next;
    logic [RUN_BITS-1:0] out_cur_cnt_reg, out_cur_cnt_next;

    // read and write port signals
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic                we_id, we_parent, we_state, we_count;
    logic [ID_BITS-1:0]  wr_id, wr_parent;
    task_state_t         wr_state;
    logic [RUN_BITS-1:0] wr_count;

    logic [CW-1:0]       limit;
    logic                issue;
    logic                occupied;
    logic                match;
    logic                hit;
    logic                table_full;
    logic [ID_BITS-1:0]  cur_id;
    logic [RUN_BITS-1:0] cur_cnt;

    // memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we_id)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (we_parent)
        begin
            parent_mem[wr_addr] <= wr_parent;
        end
        if (we_state)
        begin
            state_mem[wr_addr] <= wr_state;
        end
        if (we_count)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        rd_addr_reg   <= rd_addr;
        rd_id_reg     <= id_mem[rd_addr];
        rd_parent_reg <= parent_mem[rd_addr];
        rd_state_reg  <= state_mem[rd_addr];
        rd_count_reg  <= count_mem[rd_addr];
    end

    // slots are only ever filled in order, so the fill count marks free entries
    assign occupied   = ({1'b0, rd_addr_reg} < fill_reg);
    assign table_full = (fill_reg == ALL_SLOTS);
    assign limit      = (cmd.scan == SCAN_PICK) ? ALL_SLOTS : fill_reg;
    assign issue      = (cmd.scan != SCAN_NONE) && (cnt_reg < limit);
    assign rd_addr    = issue ? idx_reg : cur_reg;

    always_comb
    begin
        case (cmd.scan)
            SCAN_FIND:  match = (rd_id_reg == tid_reg);
            SCAN_CHILD: match = (rd_parent_reg == tid_reg);
            SCAN_PICK:  match = (rd_state_reg == TS_READY) || (rd_state_reg == TS_RUNNING);
            default:    match = 1'b0;
        endcase
    end

    assign hit = eval_reg && occupied && match;

    assign stat.op        = op_reg;
    assign stat.hit       = hit;
    assign stat.exhausted = !eval_reg && (cnt_reg == limit);

    assign cur_id  = occupied ? rd_id_reg : '0;
    assign cur_cnt = occupied ? rd_count_reg : '0;

    // write port
    always_comb
    begin
        wr_addr   = rd_addr_reg;
        we_id     = 1'b0;
        we_parent = 1'b0;
        we_state  = 1'b0;
        we_count  = 1'b0;
        wr_id     = next_id_reg;
        wr_parent = pid_reg;
        wr_state  = TS_READY;
        wr_count  = '0;
        if (cmd.create && !table_full)
        begin
            wr_addr   = fill_reg[IW-1:0];
            we_id     = 1'b1;
            we_parent = 1'b1;
            we_state  = 1'b1;
            we_count  = 1'b1;
        end
        else if (cmd.apply)
        begin
            wr_addr = hit_slot_reg;
            case (op_reg)
                OP_BLOCK:
                begin
                    we_state = 1'b1;
                    wr_state = TS_BLOCKED;
                end
                OP_UNBLOCK:
                begin
                    we_state = (hit_state_reg == TS_BLOCKED);
                    wr_state = TS_READY;
                end
                OP_SLEEP:
                begin
                    we_state = 1'b1;
                    wr_state = TS_SLEEPING;
                end
                OP_STOP:
                begin
                    we_state = 1'b1;
                    wr_state = TS_STOPPED;
                end
                OP_CONTINUE:
                begin
                    we_state = (hit_state_reg == TS_STOPPED);
                    wr_state = TS_READY;
                end
                OP_EXIT:
                begin
                    we_state = 1'b1;
                    wr_state = TS_ZOMBIE;
                end
                default:
                begin
                    we_state = 1'b0;
                end
            endcase
        end
        else if (hit && (cmd.scan == SCAN_CHILD))
        begin
            // orphans are handed to task 1
            we_parent = 1'b1;
            wr_parent = ROOT_ID;
        end
        else if (hit && (cmd.scan == SCAN_PICK))
        begin
            we_state = 1'b1;
            wr_state = TS_RUNNING;
            we_count = 1'b1;
            wr_count = (rd_count_reg == '1) ? rd_count_reg : rd_count_reg + RUN_BITS'(1);
        end
    end

    // register next values
    always_comb
    begin
        op_next          = op_reg;
        fill_next        = fill_reg;
        cur_next         = cur_reg;
        next_id_next     = next_id_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        eval_next        = issue && (cmd.init_kind == SCAN_NONE);
        tid_next         = tid_reg;
        pid_next         = pid_reg;
        hit_slot_next    = hit_slot_reg;
        hit_state_next   = hit_state_reg;
        status_next      = status_reg;
        result_next      = result_reg;
        out_status_next  = out_status_reg;
        out_result_next  = out_result_reg;
        out_cur_id_next  = out_cur_id_reg;
        out_cur_cnt_next = out_cur_cnt_reg;

        if (cmd.accept)
        begin
            op_next     = op_t'(operation);
            tid_next    = target_id;
            pid_next    = parent_id;
            status_next = STAT_DONE;
            result_next = '0;
        end

        // scan engine: issue one read per cycle, evaluate it the next cycle
        if (cmd.init_kind != SCAN_NONE)
        begin
            cnt_next = '0;
            if (cmd.init_kind == SCAN_PICK)
            begin
                idx_next = (cur_reg == LAST_IDX) ? '0 : cur_reg + IW'(1);
            end
            else
            begin
                idx_next = '0;
            end
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CW'(1);
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
        end

        if (cmd.create)
        begin
            if (table_full)
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                fill_next    = fill_reg + CW'(1);
                result_next  = next_id_reg;
                next_id_next = (next_id_reg == '1) ? ROOT_ID : next_id_reg + ID_BITS'(1);
            end
        end

        case (cmd.scan)
            SCAN_FIND:
            begin
                if (hit)
                begin
                    hit_slot_next  = rd_addr_reg;
                    hit_state_next = rd_state_reg;
                end
                else if (stat.exhausted)
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            SCAN_PICK:
            begin
                if (hit)
                begin
                    cur_next    = rd_addr_reg;
                    result_next = rd_id_reg;
                end
                else if (stat.exhausted)
                begin
                    status_next = STAT_NOTHING;
                end
            end
            default:
            begin
                hit_slot_next = hit_slot_reg;
            end
        endcase

        if (cmd.load)
        begin
            out_cur_id_next  = cur_id;
            out_cur_cnt_next = cur_cnt;
            if (op_reg == OP_QUERY)
            begin
                out_result_next = cur_id;
                out_status_next = (cur_id != '0) ? STAT_DONE : STAT_NOT_FOUND;
            end
            else
            begin
                out_result_next = result_reg;
                out_status_next = status_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_QUERY;
            fill_reg    <= '0;
            cur_reg     <= '0;
            next_id_reg <= ROOT_ID;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            eval_reg    <= 1'b0;
        end
        else
        begin
            op_reg      <= op_next;
            fill_reg    <= fill_next;
            cur_reg     <= cur_next;
            next_id_reg <= next_id_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            eval_reg    <= eval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg         <= tid_next;
        pid_reg         <= pid_next;
        hit_slot_reg    <= hit_slot_next;
        hit_state_reg   <= hit_state_next;
        status_reg      <= status_next;
        result_reg      <= result_next;
        out_status_reg  <= out_status_next;
        out_result_reg  <= out_result_next;
        out_cur_id_reg  <= out_cur_id_next;
        out_cur_cnt_reg <= out_cur_cnt_next;
    end

    assign status            = out_status_reg;
    assign result_id         = out_result_reg;
    assign current_id        = out_cur_id_reg;
    assign current_run_count = out_cur_cnt_reg;

endmodule

### hdl/ttrr_ctrl.sv
// ----------------------------------------------------------------------------
// ttrr_ctrl
// Command sequencer: steps each command through create, lookup, state
// update, child hand-over, round-robin pick and result load.
// ----------------------------------------------------------------------------
module ttrr_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ttrr_pkg::OP_BITS-1:0] operation,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ttrr_pkg::dp_cmd_t            cmd,
    input  ttrr_pkg::dp_stat_t           stat
);
    import ttrr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.create     = 1'b0;
        cmd.apply      = 1'b0;
        cmd.load       = 1'b0;
        cmd.scan       = SCAN_NONE;
        cmd.init_kind  = SCAN_NONE;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (op_t'(operation))
                        OP_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        OP_SCHEDULE:
                        begin
                            cmd.init_kind = SCAN_PICK;
                            state_next    = S_PICK;
                        end
                        OP_BLOCK, OP_UNBLOCK, OP_SLEEP, OP_STOP, OP_CONTINUE, OP_EXIT:
                        begin
                            cmd.init_kind = SCAN_FIND;
                            state_next    = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_CUR_RD;
                        end
                    endcase
                end
            end
            S_CREATE:
            begin
                cmd.create = 1'b1;
                state_next = S_CUR_RD;
            end
            S_FIND:
            begin
                cmd.scan = SCAN_FIND;
                if (stat.hit)
                begin
                    state_next = S_APPLY;
                end
                else if (stat.exhausted)
                begin
                    state_next = S_CUR_RD;
                end
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                case (stat.op)
                    OP_SLEEP, OP_STOP:
                    begin
                        cmd.init_kind = SCAN_PICK;
                        state_next    = S_PICK;
                    end
                    OP_EXIT:
                    begin
                        cmd.init_kind = SCAN_CHILD;
                        state_next    = S_CHILD;
                    end
                    default:
                    begin
                        state_next = S_CUR_RD;
                    end
                endcase
            end
            S_CHILD:
            begin
                cmd.scan = SCAN_CHILD;
                if (stat.exhausted)
                begin
                    cmd.init_kind = SCAN_PICK;
                    state_next    = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.scan = SCAN_PICK;
                if (stat.hit || stat.exhausted)
                begin
                    state_next = S_CUR_RD;
                end
            end
            S_CUR_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/task_table_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// task_table_round_robin_scheduler
// Hardware task table with round-robin scheduling.
//
// One command beat in (operation, target_id, parent_id) gives one result beat
// out (status, result_id, current_id, current_run_count), both valid/ready.
// Commands are processed one at a time; a new command is taken as soon as the
// previous one has been written to the output register, even if that result
// is still waiting for the receiver. A stalled receiver holds the result and,
// once the next command is finished, holds the block in its load step.
// The table sits in memories read one entry per cycle through a registered
// port, so the time from accept to next accept grows with the entries that
// the command walks (N entries, F slots in use):
//   create, query, undefined code: no walk
//   schedule: up to N entries
//   block, unblock, continue: up to F entries
//   sleep, stop: up to F + N entries; exit: up to 2F + N entries
// Reset empties the table at once (fill count), selects slot 0 as current and
// restarts task ids at 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler #(
    parameter int TABLE_ENTRIES = ttrr_pkg::DEF_TABLE_ENTRIES,
    parameter int ID_BITS       = ttrr_pkg::DEF_ID_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ttrr_pkg::OP_BITS-1:0]     operation,
    input  logic [ID_BITS-1:0]               target_id,
    input  logic [ID_BITS-1:0]               parent_id,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ttrr_pkg::STATUS_BITS-1:0] status,
    output logic [ID_BITS-1:0]               result_id,
    output logic [ID_BITS-1:0]               current_id,
    output logic [ttrr_pkg::RUN_BITS-1:0]    current_run_count
);
    import ttrr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ttrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ttrr_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BITS       (ID_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .operation         (operation),
        .target_id         (target_id),
        .parent_id         (parent_id),
        .cmd               (cmd),
        .stat              (stat),
        .status            (status),
        .result_id         (result_id),
        .current_id        (current_id),
        .current_run_count (current_run_count)
    );

endmodule
